>>> rtl/core/htsd_pkg.sv
// Shared types and codes for the threshold scan driver.
package htsd_pkg;

  // Command codes carried on the mode input.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  // Pixel byte layout (RGB332).
  localparam int RED_LSB   = 5;
  localparam int GREEN_LSB = 2;
  localparam int BLUE_LSB  = 0;

  // Decoded operation passed from front to back through the queue.
  typedef struct packed {
    logic scan;
    logic wr_upper;
    logic wr_lower;
  } htsd_ctrl_t;

  localparam int CTRL_W = $bits(htsd_ctrl_t);

endpackage

>>> rtl/core/htsd_front.sv
// Front end: decodes commands into queue words with bank select and address.
module htsd_front #(
  parameter int PANEL_COLUMNS = 64,
  parameter int PANEL_ROWS    = 32,
  parameter int ADDR_W        = 10
) (
  input  logic                     accept,
  input  logic                     mode,
  input  logic [4:0]               pixel_row,
  input  logic [5:0]               pixel_col,
  input  logic [7:0]               pixel_color,
  output logic                     push,
  output htsd_pkg::htsd_ctrl_t     ctrl,
  output logic [ADDR_W-1:0]        addr,
  output logic [7:0]               data
);
  import htsd_pkg::*;

  localparam int HALF_ROWS = PANEL_ROWS / 2;

  logic              in_panel;
  logic              lower_half;
  logic [4:0]        bank_row;
  logic [ADDR_W:0]   addr_full;

  always_comb begin
    in_panel   = ({2'b00, pixel_row} < 7'(PANEL_ROWS)) &&
                 ({3'b000, pixel_col} < 9'(PANEL_COLUMNS));
    lower_half = ({2'b00, pixel_row} >= 7'(HALF_ROWS));
    bank_row   = lower_half ? 5'({2'b00, pixel_row} - 7'(HALF_ROWS)) : pixel_row;
    addr_full  = (ADDR_W+1)'(bank_row) * (ADDR_W+1)'(PANEL_COLUMNS) +
                 (ADDR_W+1)'(pixel_col);
  end

  always_comb begin
    ctrl.scan     = (mode == MODE_SCAN);
    ctrl.wr_upper = (mode == MODE_WRITE) && in_panel && !lower_half;
    ctrl.wr_lower = (mode == MODE_WRITE) && in_panel && lower_half;
    addr          = addr_full[ADDR_W-1:0];
    data          = pixel_color;
    // drop writes that fall outside the panel
    push          = accept && (ctrl.scan || ctrl.wr_upper || ctrl.wr_lower);
  end

endmodule

>>> rtl/core/htsd_queue.sv
// Two-entry queue that decouples the front end from the back end.
module htsd_queue #(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  assign rdata = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

>>> rtl/core/htsd_back.sv
// Back end: frame store banks, clearing sweep, scan counters and plane compare.
module htsd_back #(
  parameter int PANEL_COLUMNS = 64,
  parameter int PANEL_ROWS    = 32,
  parameter int PLANE_COUNT   = 7,
  parameter int ADDR_W        = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     op_ready,
  input  htsd_pkg::htsd_ctrl_t     op_ctrl,
  input  logic [ADDR_W-1:0]        op_addr,
  input  logic [7:0]               op_data,
  output logic                     pop,
  output logic                     clearing,
  output logic                     result_strobe,
  output logic                     upper_red,
  output logic                     upper_green,
  output logic                     upper_blue,
  output logic                     lower_red,
  output logic                     lower_green,
  output logic                     lower_blue,
  output logic [3:0]               row_address,
  output logic [5:0]               column_index,
  output logic                     latch_now,
  output logic                     frame_done
);
  import htsd_pkg::*;

  localparam int HALF_ROWS   = PANEL_ROWS / 2;
  localparam int UPPER_DEPTH = HALF_ROWS * PANEL_COLUMNS;
  localparam int LOWER_DEPTH = (PANEL_ROWS - HALF_ROWS) * PANEL_COLUMNS;
  localparam int UA_W        = (UPPER_DEPTH > 1) ? $clog2(UPPER_DEPTH) : 1;
  localparam int COL_W       = $clog2(PANEL_COLUMNS);
  localparam int ROW_W       = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

  logic [7:0] upper_mem [UPPER_DEPTH];
  logic [7:0] lower_mem [LOWER_DEPTH];

  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  scan_column;
  logic [ROW_W-1:0]  scan_row;
  logic [2:0]        threshold_plane;

  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [2:0]        s1_plane;
  logic              s1_last_col;
  logic              s1_frame;
  logic [7:0]        upper_rd;
  logic [7:0]        lower_rd;

  logic              last_col;
  logic              last_row;
  logic              last_plane;
  logic              do_scan;
  logic              clr_in_upper;
  logic [ADDR_W:0]   scan_full;
  logic [ADDR_W-1:0] scan_addr;
  logic [2:0]        upper_lit;
  logic [2:0]        lower_lit;

  function automatic logic [2:0] light(input logic [7:0] px, input logic [2:0] plane);
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
    red   = px[RED_LSB +: 3];
    green = px[GREEN_LSB +: 3];
    blue  = {1'b0, px[BLUE_LSB +: 2]};
    return {red > plane, green > plane, blue > plane};
  endfunction

  always_comb begin
    pop          = op_ready && !clearing;
    do_scan      = pop && op_ctrl.scan;
    last_col     = (scan_column == COL_W'(PANEL_COLUMNS - 1));
    last_row     = (scan_row == ROW_W'(HALF_ROWS - 1));
    last_plane   = (threshold_plane == 3'(PLANE_COUNT - 1));
    scan_full    = (ADDR_W+1)'(scan_row) * (ADDR_W+1)'(PANEL_COLUMNS) +
                   (ADDR_W+1)'(scan_column);
    scan_addr    = scan_full[ADDR_W-1:0];
    clr_in_upper = ({1'b0, clr_addr} < (ADDR_W+1)'(UPPER_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing        <= 1'b1;
      clr_addr        <= '0;
      scan_column     <= '0;
      scan_row        <= '0;
      threshold_plane <= '0;
      s1_valid        <= 1'b0;
    end else begin
      s1_valid <= do_scan;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(LOWER_DEPTH - 1)) clearing <= 1'b0;
      end
      // advance column, then row, then plane
      if (do_scan) begin
        if (!last_col) begin
          scan_column <= scan_column + 1'b1;
        end else begin
          scan_column <= '0;
          if (!last_row) begin
            scan_row <= scan_row + 1'b1;
          end else begin
            scan_row        <= '0;
            threshold_plane <= last_plane ? 3'd0 : threshold_plane + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      s1_col      <= scan_column;
      s1_row      <= scan_row;
      s1_plane    <= threshold_plane;
      s1_last_col <= last_col;
      s1_frame    <= last_col && last_row && last_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing && clr_in_upper) begin
      upper_mem[clr_addr[UA_W-1:0]] <= 8'd0;
    end else if (pop && op_ctrl.wr_upper) begin
      upper_mem[op_addr[UA_W-1:0]] <= op_data;
    end
    if (do_scan) upper_rd <= upper_mem[scan_addr[UA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      lower_mem[clr_addr] <= 8'd0;
    end else if (pop && op_ctrl.wr_lower) begin
      lower_mem[op_addr] <= op_data;
    end
    if (do_scan) lower_rd <= lower_mem[scan_addr];
  end

  always_comb begin
    upper_lit     = light(upper_rd, s1_plane);
    lower_lit     = light(lower_rd, s1_plane);
    result_strobe = s1_valid;
    upper_red     = upper_lit[2];
    upper_green   = upper_lit[1];
    upper_blue    = upper_lit[0];
    lower_red     = lower_lit[2];
    lower_green   = lower_lit[1];
    lower_blue    = lower_lit[0];
    row_address   = 4'(s1_row);
    column_index  = 6'(s1_col);
    latch_now     = s1_last_col;
    frame_done    = s1_frame;
  end

endmodule

>>> rtl/core/hub75_threshold_scan_driver.sv
// Top level of the HUB75 threshold scan driver.
//
// Commands enter on start/busy: a command is taken at a clock edge where start
// is high and busy is low. mode selects a pixel write (pixel_row, pixel_col,
// pixel_color) or a scan request. Writes outside the panel are dropped and no
// write gives a result.
// Each scan request gives one column word on the result ports, valid for one
// cycle while result_strobe is high; the receiver cannot stall it. The column
// carries the lit channels of the scanned row and the row half a panel below,
// plus row address, column index, latch and end-of-frame flags.
// A request is registered in the queue, then in the read stage that drives the
// column word. The two-word queue between decoder and frame store lets one
// command be taken every cycle while busy is low; busy rises on a full queue.
// Frame store: two banks (upper and lower half), each with its own write and read
// port, so both pixels of a column are read in the same cycle.
// Reset: scan position returns to column 0, row 0, plane 0 and the frame store
// is swept to zero, one address per cycle in both banks, covering
// (PANEL_ROWS - PANEL_ROWS/2) * PANEL_COLUMNS addresses (1024 by default); busy
// stays high for that sweep.
module hub75_threshold_scan_driver #(
  parameter int PANEL_COLUMNS = 64,
  parameter int PANEL_ROWS    = 32,
  parameter int PLANE_COUNT   = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [4:0] pixel_row,
  input  logic [5:0] pixel_col,
  input  logic [7:0] pixel_color,
  output logic       result_strobe,
  output logic       upper_red,
  output logic       upper_green,
  output logic       upper_blue,
  output logic       lower_red,
  output logic       lower_green,
  output logic       lower_blue,
  output logic [3:0] row_address,
  output logic [5:0] column_index,
  output logic       latch_now,
  output logic       frame_done
);
  import htsd_pkg::*;

  localparam int HALF_ROWS   = PANEL_ROWS / 2;
  localparam int LOWER_DEPTH = (PANEL_ROWS - HALF_ROWS) * PANEL_COLUMNS;
  localparam int ADDR_W      = $clog2(LOWER_DEPTH);
  localparam int QW          = CTRL_W + ADDR_W + 8;

  logic              accept;
  logic              f_push;
  htsd_ctrl_t        f_ctrl;
  logic [ADDR_W-1:0] f_addr;
  logic [7:0]        f_data;
  logic [QW-1:0]     q_wdata;
  logic [QW-1:0]     q_rdata;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  htsd_ctrl_t        b_ctrl;
  logic [ADDR_W-1:0] b_addr;
  logic [7:0]        b_data;
  logic              clearing;

  assign busy    = clearing || q_full;
  assign accept  = start && !busy;
  assign q_wdata = {f_ctrl, f_addr, f_data};
  assign {b_ctrl, b_addr, b_data} = q_rdata;

  htsd_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .accept      (accept),
    .mode        (mode),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .pixel_color (pixel_color),
    .push        (f_push),
    .ctrl        (f_ctrl),
    .addr        (f_addr),
    .data        (f_data)
  );

  htsd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  htsd_back #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS),
    .PLANE_COUNT   (PLANE_COUNT),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .op_ready      (!q_empty),
    .op_ctrl       (b_ctrl),
    .op_addr       (b_addr),
    .op_data       (b_data),
    .pop           (q_pop),
    .clearing      (clearing),
    .result_strobe (result_strobe),
    .upper_red     (upper_red),
    .upper_green   (upper_green),
    .upper_blue    (upper_blue),
    .lower_red     (lower_red),
    .lower_green   (lower_green),
    .lower_blue    (lower_blue),
    .row_address   (row_address),
    .column_index  (column_index),
    .latch_now     (latch_now),
    .frame_done    (frame_done)
  );

  a_no_result_after_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !result_strobe)
    else $error("column word issued while frame store was being cleared");

  a_frame_done_latches: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && frame_done) |-> latch_now)
    else $error("end of frame flagged on a column that does not latch");

  a_column_advance: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !latch_now) ##1 result_strobe |->
      (column_index == 6'($past(column_index) + 6'd1)) &&
      (row_address == $past(row_address)))
    else $error("back-to-back columns did not advance within the row");

endmodule

>>> sim/htsd_column_monitor.sv
// Column monitor: models the scan driver, predicts each column word and checks the result port.
module htsd_column_monitor (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       mode,
  input  logic [4:0] pixel_row,
  input  logic [5:0] pixel_col,
  input  logic [7:0] pixel_color,
  input  logic       result_strobe,
  input  logic       upper_red,
  input  logic       upper_green,
  input  logic       upper_blue,
  input  logic       lower_red,
  input  logic       lower_green,
  input  logic       lower_blue,
  input  logic [3:0] row_address,
  input  logic [5:0] column_index,
  input  logic       latch_now,
  input  logic       frame_done,
  output int         error_count,
  output int         columns_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import htsd_pkg::*;

  localparam int COLUMNS     = 64;
  localparam int ROWS        = 32;
  localparam int HALF_ROWS   = ROWS / 2;
  localparam int PLANES      = 7;

  typedef struct packed {
    logic       upper_red;
    logic       upper_green;
    logic       upper_blue;
    logic       lower_red;
    logic       lower_green;
    logic       lower_blue;
    logic [3:0] row_address;
    logic [5:0] column_index;
    logic       latch_now;
    logic       frame_done;
  } column_word_t;

  logic [7:0]   pixel_bytes [ROWS*COLUMNS];
  logic [5:0]   scan_col;
  logic [3:0]   scan_row;
  logic [2:0]   plane;
  column_word_t column_words_due [$];

  // One bit per channel, red first; a channel is lit when it beats the plane.
  function automatic logic [2:0] lit_channels(input logic [7:0] px, input logic [2:0] t);
    logic [2:0] red, green, blue;
    red   = px[RED_LSB +: 3];
    green = px[GREEN_LSB +: 3];
    blue  = {1'b0, px[BLUE_LSB +: 2]};
    return {red > t, green > t, blue > t};
  endfunction

  // Shade the column at the scan position, then advance column, row, plane.
  task automatic shade_next_column(output column_word_t w);
    logic [2:0] up, lo;
    logic       last_col, last_row, last_plane;
    up = lit_channels(pixel_bytes[int'(scan_row) * COLUMNS + int'(scan_col)], plane);
    lo = lit_channels(pixel_bytes[(int'(scan_row) + HALF_ROWS) * COLUMNS + int'(scan_col)],
                      plane);
    last_col   = (int'(scan_col) == COLUMNS - 1);
    last_row   = (int'(scan_row) == HALF_ROWS - 1);
    last_plane = (int'(plane) == PLANES - 1);
    {w.upper_red, w.upper_green, w.upper_blue} = up;
    {w.lower_red, w.lower_green, w.lower_blue} = lo;
    w.row_address  = scan_row;
    w.column_index = scan_col;
    w.latch_now    = last_col;
    w.frame_done   = last_col && last_row && last_plane;
    if (!last_col) begin
      scan_col = scan_col + 6'd1;
    end else begin
      scan_col = '0;
      if (!last_row) begin
        scan_row = scan_row + 4'd1;
      end else begin
        scan_row = '0;
        plane    = last_plane ? 3'd0 : plane + 3'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    column_word_t due;
    column_word_t w;
    if (rst) begin
      foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
      scan_col = '0;
      scan_row = '0;
      plane    = '0;
      column_words_due.delete();
    end else begin
      // Check the result first so a word can never match its own request.
      if (result_strobe) begin
        if (column_words_due.size() == 0) begin
          error_count++;
          $display("%0t: column word with none due: expected nothing, got col %0d row %0d",
                   $time, column_index, row_address);
        end else begin
          due = column_words_due.pop_front();
          check_field("upper_red",    due.upper_red,    upper_red);
          check_field("upper_green",  due.upper_green,  upper_green);
          check_field("upper_blue",   due.upper_blue,   upper_blue);
          check_field("lower_red",    due.lower_red,    lower_red);
          check_field("lower_green",  due.lower_green,  lower_green);
          check_field("lower_blue",   due.lower_blue,   lower_blue);
          check_field("row_address",  due.row_address,  row_address);
          check_field("column_index", due.column_index, column_index);
          check_field("latch_now",    due.latch_now,    latch_now);
          check_field("frame_done",   due.frame_done,   frame_done);
        end
      end
      if (start && !busy) begin
        if (mode == MODE_WRITE) begin
          pixel_bytes[{pixel_row, pixel_col}] = pixel_color;
        end else begin
          shade_next_column(w);
          column_words_due.push_back(w);
        end
      end
    end
    columns_pending = column_words_due.size();
  end

endmodule

>>> sim/hub75_threshold_scan_driver_tb.sv
// Testbench top: clock, reset, write and scan word stimulus, watchdog and verdict.
module hub75_threshold_scan_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htsd_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_WORDS  = 250;
  localparam int HEAVY_WORDS  = 280;

  logic       clk;
  logic       rst         = 1'b1;
  logic       start       = 1'b0;
  logic       busy;
  logic       mode        = MODE_WRITE;
  logic [4:0] pixel_row   = '0;
  logic [5:0] pixel_col   = '0;
  logic [7:0] pixel_color = '0;
  logic       result_strobe;
  logic       upper_red;
  logic       upper_green;
  logic       upper_blue;
  logic       lower_red;
  logic       lower_green;
  logic       lower_blue;
  logic [3:0] row_address;
  logic [5:0] column_index;
  logic       latch_now;
  logic       frame_done;

  int error_count;
  int columns_pending;
  int idle_pct     = 0;
  int scans_issued = 0;
  int quiet_cycles = 0;

  hub75_threshold_scan_driver u_dut (.*);

  htsd_column_monitor u_column_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic m, input logic [4:0] r, input logic [5:0] c,
                           input logic [7:0] color);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    mode        = m;
    pixel_row   = r;
    pixel_col   = c;
    pixel_color = color;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == MODE_SCAN) scans_issued++;
    @(negedge clk);
  endtask

  // Half of the writes land just ahead of the scan in the current row pair.
  task automatic send_random_word(input int scan_pct);
    int         at_col, at_row;
    logic [4:0] r;
    logic [5:0] c;
    logic [7:0] color;
    at_col = scans_issued % 64;
    at_row = (scans_issued / 64) % 16;
    r      = 5'($urandom);
    c      = 6'($urandom);
    if ($urandom_range(9) == 0) color = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    else color = 8'($urandom);
    if ($urandom_range(99) < scan_pct) begin
      send_word(MODE_SCAN, r, c, color);
    end else begin
      if ($urandom_range(1) == 1) begin
        r = 5'(at_row + (($urandom_range(1) == 1) ? 16 : 0));
        c = 6'(at_col + $urandom_range(12));
      end
      send_word(MODE_WRITE, r, c, color);
    end
  endtask

  // Hold off until every column word due has come back.
  task automatic drain_columns();
    start = 1'b0;
    wait (columns_pending == 0);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if ((start && !busy) || result_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** hub75_threshold_scan_driver: FAILED **");
      $finish;
    end
  end

  initial begin
    int plan [4];
    plan = '{0, 58, 26, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Channel extremes in both halves, three of the panel corners and an overwrite.
    send_word(MODE_WRITE, 5'd0,  6'd0,  8'h00);
    send_word(MODE_WRITE, 5'd0,  6'd0,  8'hFF);
    send_word(MODE_WRITE, 5'd16, 6'd0,  8'hFF);
    send_word(MODE_WRITE, 5'd0,  6'd1,  8'hE0);
    send_word(MODE_WRITE, 5'd16, 6'd1,  8'h1C);
    send_word(MODE_WRITE, 5'd0,  6'd2,  8'h03);
    send_word(MODE_WRITE, 5'd16, 6'd2,  8'h24);
    send_word(MODE_WRITE, 5'd0,  6'd3,  8'h49);
    send_word(MODE_WRITE, 5'd16, 6'd3,  8'hB6);
    send_word(MODE_WRITE, 5'd31, 6'd63, 8'hFF);
    send_word(MODE_WRITE, 5'd15, 6'd63, 8'h92);
    send_word(MODE_WRITE, 5'd0,  6'd63, 8'h6D);
    repeat (5) send_word(MODE_SCAN, 5'd31, 6'd63, 8'hFF);
    drain_columns();

    // Mixed words under each sender idling setting.
    foreach (plan[p]) begin
      idle_pct = plan[p];
      repeat (PHASE_WORDS) send_random_word(55);
      drain_columns();
    end

    // Scan-heavy run with the idling setting changed now and then.
    for (int n = 0; n < HEAVY_WORDS; n++) begin
      if (n % 70 == 0) begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 26;
          default: idle_pct = 58;
        endcase
      end
      send_random_word(85);
    end

    start = 1'b0;
    wait (columns_pending == 0);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** hub75_threshold_scan_driver: PASSED **");
    end else begin
      $display("** hub75_threshold_scan_driver: FAILED **");
    end
    $finish;
  end

endmodule
